// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers for humidity_temp_frame_checker, sampled on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/htfc_pkg.sv =====
// ----------------------------------------------------------------------------
// htfc_pkg
// types, constants and the crc-8 byte update of the frame checker
// ----------------------------------------------------------------------------
package htfc_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  STATUS_MASK = 8'hFC;
  localparam logic [14:0] T_SCALE     = 15'd17572;
  localparam logic [14:0] RH_SCALE    = 15'd12500;
  localparam logic signed [15:0] T_OFFSET  = -16'sd4685;
  localparam logic signed [15:0] RH_OFFSET = -16'sd600;
  localparam logic KIND_TEMP  = 1'b0;
  localparam logic KIND_HUMID = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       measure_kind;
  } in_item_t;

  typedef struct packed {
    logic signed [14:0] value_centi;
    logic               kind_out;
    logic               crc_error;
  } out_item_t;

  // status of the transaction held in the input register
  typedef struct packed {
    logic        has_result;
    logic        crc_error;
    logic        kind;
    logic [15:0] raw;
  } frame_res_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/htfc_frame.sv =====
// ----------------------------------------------------------------------------
// htfc_frame
// byte position tracking, running crc and raw reading capture
// ----------------------------------------------------------------------------
module htfc_frame
  import htfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   item,
  input  logic       fire,
  output frame_res_t res
);

  typedef enum logic [1:0] {
    POS_HIGH  = 2'd0,
    POS_LOW   = 2'd1,
    POS_CHECK = 2'd2
  } pos_t;

  pos_t       pos_r, pos_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [7:0] high_r, high_nxt;
  logic [7:0] low_r, low_nxt;
  logic       kind_r, kind_nxt;

  assign res.has_result = !item.frame_start && (pos_r == POS_CHECK);
  assign res.crc_error  = (item.rx_byte != crc_r);
  assign res.kind       = kind_r;
  assign res.raw        = {high_r, low_r & STATUS_MASK};

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    high_nxt = high_r;
    low_nxt  = low_r;
    kind_nxt = kind_r;
    if (fire) begin
      if (item.frame_start) begin
        kind_nxt = item.measure_kind;
        high_nxt = item.rx_byte;
        crc_nxt  = crc_byte(8'h00, item.rx_byte);
        pos_nxt  = POS_LOW;
      end else begin
        unique case (pos_r)
          POS_LOW: begin
            low_nxt = item.rx_byte;
            crc_nxt = crc_byte(crc_r, item.rx_byte);
            pos_nxt = POS_CHECK;
          end
          default: begin
            pos_nxt = POS_HIGH;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_HIGH;
      crc_r  <= 8'h00;
      high_r <= 8'h00;
      low_r  <= 8'h00;
      kind_r <= KIND_TEMP;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      high_r <= high_nxt;
      low_r  <= low_nxt;
      kind_r <= kind_nxt;
    end
  end

endmodule

// ===== rtl/core/htfc_conv.sv =====
// ----------------------------------------------------------------------------
// htfc_conv
// linear conversion of the raw reading to signed hundredths
// ----------------------------------------------------------------------------
module htfc_conv
  import htfc_pkg::*;
(
  input  logic               kind,
  input  logic [15:0]        raw,
  output logic signed [14:0] value_centi
);

  logic [14:0]        scale;
  logic signed [15:0] offset;
  logic [30:0]        prod;
  logic signed [15:0] sum;

  always_comb begin
    case (kind)
      KIND_HUMID: begin
        scale  = RH_SCALE;
        offset = RH_OFFSET;
      end
      default: begin
        scale  = T_SCALE;
        offset = T_OFFSET;
      end
    endcase
  end

  // floor(scale * raw / 65536), at most 15 bits
  assign prod = 31'(raw) * 31'(scale);
  assign sum  = offset + $signed({1'b0, prod[30:16]});
  assign value_centi = sum[14:0];

endmodule

// ===== rtl/core/humidity_temp_frame_checker.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker
// crc-8 check and linear conversion of a three-byte sensor response
// ----------------------------------------------------------------------------
// Bytes enter one transaction per clock while in_stall is low: data high
// (frame_start = 1, with the measurement kind), data low, checksum. A crc-8
// (poly 0x31, init 0) runs over the two data bytes; the checksum byte yields
// one result with value_centi in signed hundredths (rounded down), kind_out
// and crc_error; on a mismatch value_centi is 0. Bytes arriving outside a
// frame are dropped, and frame_start restarts a frame at any point.
// Throughput is one byte per clock unless a stalled output holds a result; a
// result passes through the input register (crc, position tracking,
// conversion multiply) and then the result register before reaching out_.
`include "assert_macros.svh"

module humidity_temp_frame_checker
  import htfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // input register
  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       s1_move;
  frame_res_t fres;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic signed [14:0] conv_value;
  logic      out_load;

  htfc_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (s1_item_r),
    .fire  (s1_move),
    .res   (fres)
  );

  htfc_conv u_conv (
    .kind        (fres.kind),
    .raw         (fres.raw),
    .value_centi (conv_value)
  );

  // a transaction with no result drains regardless of the output side
  assign s1_move  = s1_valid_r && (!fres.has_result || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign out_load = s1_move && fres.has_result;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (out_load) begin
      out_item_r.value_centi <= fres.crc_error ? 15'sd0 : conv_value;
      out_item_r.kind_out    <= fres.kind;
      out_item_r.crc_error   <= fres.crc_error;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // checks on this block's own logic
  `ASSERT_SAME(a_stall_needs_item, in_stall, s1_valid_r && fres.has_result)
  `ASSERT_NEXT(a_held_item_stays, s1_valid_r && !s1_move, s1_valid_r && $stable(s1_item_r))
  `ASSERT_SAME(a_error_zero, out_valid && out_data.crc_error, out_data.value_centi == 15'sd0)
  `ASSERT_SAME(a_value_range, out_valid && !out_data.crc_error,
               out_data.value_centi >= -15'sd4685 && out_data.value_centi <= 15'sd12886)

endmodule
